@@ src/pwle_pkg.sv @@
`default_nettype none

package pwle_pkg;

    // Field widths.
    localparam int LEVEL_W    = 16;
    localparam int POS_W      = 25;
    localparam int LEN_W      = 24;
    localparam int INC_W      = 24;
    localparam int SEG_W      = 3;
    localparam int SEGCNT_W   = 4;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Segment table depth and the largest usable segment count.
    localparam int SEGMENTS = 8;
    localparam logic [SEGCNT_W-1:0] SEG_CAP = SEGCNT_W'(SEGMENTS < 8 ? SEGMENTS : 8);

    // Interpolation datapath widths.
    localparam int DIFF_W    = LEVEL_W + 1;
    localparam int PROD_W    = DIFF_W + POS_W + 1;
    localparam int MAG_W     = LEVEL_W + POS_W;
    localparam int DIV_STEPS = MAG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Reset values of the configuration registers.
    localparam logic [SEGCNT_W-1:0] SEGCNT_RST = SEGCNT_W'(4);
    localparam logic [INC_W-1:0]    INC_RST    = INC_W'(256);

    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sh7FFF;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 16'sh8000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_TRIG = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEG_COUNT = 2'd0,
        CFG_REPEAT    = 2'd1,
        CFG_INC       = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic do_load;
        logic do_trig;
        logic mul_en;
        logic abs_en;
        logic div_step;
        logic out_push;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ src/pwle_ifs.sv @@
`default_nettype none

interface pwle_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [pwle_pkg::OP_W-1:0]              op;
    logic [pwle_pkg::SEG_W-1:0]             seg_index;
    logic signed [pwle_pkg::LEVEL_W-1:0]    end_level;
    logic [pwle_pkg::LEN_W-1:0]             seg_length;

    modport source (output valid, op, seg_index, end_level, seg_length, input ready);
    modport sink   (input valid, op, seg_index, end_level, seg_length, output ready);
endinterface

interface pwle_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pwle_pkg::LEVEL_W-1:0]    level;
    logic                                   running;
    logic [pwle_pkg::SEG_W-1:0]             current_segment;

    modport source (output valid, level, running, current_segment, input ready);
    modport sink   (input valid, level, running, current_segment, output ready);
endinterface

`default_nettype wire

@@ src/pwle_ctrl.sv @@
`default_nettype none

module pwle_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [pwle_pkg::OP_W-1:0]  i_in_op,
    output logic                            o_in_ready,
    input  wire pwle_pkg::t_dp_stat         i_stat,
    output pwle_pkg::t_dp_cmd               o_cmd
);

    pwle_pkg::t_state r_state;
    pwle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pwle_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (pwle_pkg::t_op'(i_in_op))
                        pwle_pkg::OP_TICK: n_state = pwle_pkg::ST_MUL;
                        pwle_pkg::OP_LOAD: o_cmd.do_load = 1'b1;
                        pwle_pkg::OP_TRIG: o_cmd.do_trig = 1'b1;
                        default: ;
                    endcase
                end
            end
            pwle_pkg::ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = pwle_pkg::ST_ABS;
            end
            pwle_pkg::ST_ABS: begin
                o_cmd.abs_en = 1'b1;
                n_state      = pwle_pkg::ST_DIV;
            end
            pwle_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = pwle_pkg::ST_FIN;
                end
            end
            pwle_pkg::ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_push = 1'b1;
                    n_state        = pwle_pkg::ST_IDLE;
                end
            end
            default: n_state = pwle_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ src/pwle_dp.sv @@
`default_nettype none

module pwle_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic [pwle_pkg::SEG_W-1:0]             i_seg_index,
    input  wire logic signed [pwle_pkg::LEVEL_W-1:0]    i_end_level,
    input  wire logic [pwle_pkg::LEN_W-1:0]             i_seg_length,
    input  wire logic                                   i_cfg_we,
    input  wire logic [pwle_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [pwle_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire pwle_pkg::t_dp_cmd                      i_cmd,
    output pwle_pkg::t_dp_stat                          o_stat,
    input  wire logic                                   i_out_ready,
    output logic                                        o_out_valid,
    output logic signed [pwle_pkg::LEVEL_W-1:0]         o_level,
    output logic                                        o_running,
    output logic [pwle_pkg::SEG_W-1:0]                  o_current_segment
);

    // Configuration registers.
    logic [pwle_pkg::SEGCNT_W-1:0] r_seg_count;
    logic                          r_repeat;
    logic [pwle_pkg::INC_W-1:0]    r_inc;

    // Segment table.
    logic signed [pwle_pkg::LEVEL_W-1:0] r_start [pwle_pkg::SEGMENTS];
    logic signed [pwle_pkg::LEVEL_W-1:0] r_end   [pwle_pkg::SEGMENTS];
    logic [pwle_pkg::LEN_W-1:0]          r_dur   [pwle_pkg::SEGMENTS];

    // Envelope position.
    logic [pwle_pkg::POS_W-1:0] r_pos;
    logic [pwle_pkg::SEG_W-1:0] r_seg;
    logic                       r_halted;

    // Interpolation datapath.
    logic signed [pwle_pkg::PROD_W-1:0] r_prod;
    logic                               r_sign;
    logic [pwle_pkg::MAG_W-1:0]         r_dq;
    logic [pwle_pkg::LEN_W-1:0]         r_rem;
    logic [pwle_pkg::DIV_CNT_W-1:0]     r_cnt;

    // Output register.
    logic                                r_out_valid;
    logic signed [pwle_pkg::LEVEL_W-1:0] r_out_level;
    logic                                r_out_running;
    logic [pwle_pkg::SEG_W-1:0]          r_out_seg;

    logic [pwle_pkg::SEGCNT_W-1:0]       used;
    logic [pwle_pkg::SEG_W-1:0]          nxt_idx;
    logic signed [pwle_pkg::LEVEL_W-1:0] cur_s;
    logic signed [pwle_pkg::LEVEL_W-1:0] cur_e;
    logic [pwle_pkg::LEN_W-1:0]          cur_len;
    logic signed [pwle_pkg::DIFF_W-1:0]  diff;
    logic signed [pwle_pkg::PROD_W-1:0]  neg_prod;
    logic [pwle_pkg::LEN_W:0]            rem_sh;
    logic [pwle_pkg::LEN_W:0]            rem_sub;
    logic                                q_bit;
    logic signed [pwle_pkg::PROD_W-1:0]  q_ext;
    logic signed [pwle_pkg::PROD_W-1:0]  q_signed;
    logic signed [pwle_pkg::PROD_W-1:0]  lvl_sum;
    logic signed [pwle_pkg::LEVEL_W-1:0] lvl_res;
    logic [pwle_pkg::POS_W:0]            pos_sum;
    logic [pwle_pkg::POS_W-1:0]          pos_sat;
    logic [pwle_pkg::POS_W-1:0]          n_pos;
    logic [pwle_pkg::SEGCNT_W-1:0]       seg_up;
    logic [pwle_pkg::SEG_W-1:0]          n_seg;
    logic                                n_halted;

    // Segment count in force: zero acts as one, and the count is capped.
    always_comb begin
        if (r_seg_count == '0) begin
            used = pwle_pkg::SEGCNT_W'(1);
        end else if (r_seg_count > pwle_pkg::SEG_CAP) begin
            used = pwle_pkg::SEG_CAP;
        end else begin
            used = r_seg_count;
        end
    end

    assign nxt_idx = i_seg_index + pwle_pkg::SEG_W'(1);
    assign cur_s   = r_start[r_seg];
    assign cur_e   = r_end[r_seg];
    assign cur_len = r_dur[r_seg];

    assign diff = {cur_e[pwle_pkg::LEVEL_W-1], cur_e} - {cur_s[pwle_pkg::LEVEL_W-1], cur_s};
    assign neg_prod = -r_prod;

    // One restoring division step: shift in the next dividend bit.
    assign rem_sh  = {r_rem, r_dq[pwle_pkg::MAG_W-1]};
    assign rem_sub = rem_sh - {1'b0, cur_len};
    assign q_bit   = (rem_sh >= {1'b0, cur_len});

    // Apply the sign to the quotient, add the start level and saturate.
    always_comb begin
        q_ext    = $signed({{(pwle_pkg::PROD_W - pwle_pkg::MAG_W){1'b0}}, r_dq});
        q_signed = r_sign ? -q_ext : q_ext;
        lvl_sum  = q_signed + pwle_pkg::PROD_W'(cur_s);
        if (cur_len == '0) begin
            lvl_res = cur_e;
        end else if (lvl_sum > pwle_pkg::PROD_W'(pwle_pkg::LEVEL_MAX)) begin
            lvl_res = pwle_pkg::LEVEL_MAX;
        end else if (lvl_sum < pwle_pkg::PROD_W'(pwle_pkg::LEVEL_MIN)) begin
            lvl_res = pwle_pkg::LEVEL_MIN;
        end else begin
            lvl_res = lvl_sum[pwle_pkg::LEVEL_W-1:0];
        end
    end

    // Advance: add the increment, move at most one segment, then wrap or stop.
    always_comb begin
        pos_sum  = {1'b0, r_pos} + (pwle_pkg::POS_W + 1)'(r_inc);
        pos_sat  = pos_sum[pwle_pkg::POS_W] ? '1 : pos_sum[pwle_pkg::POS_W-1:0];
        n_pos    = pos_sat;
        seg_up   = pwle_pkg::SEGCNT_W'(r_seg);
        n_halted = r_halted;
        if (pos_sat > pwle_pkg::POS_W'(cur_len)) begin
            seg_up = pwle_pkg::SEGCNT_W'(r_seg) + pwle_pkg::SEGCNT_W'(1);
            n_pos  = pos_sat - pwle_pkg::POS_W'(cur_len);
        end
        n_seg = seg_up[pwle_pkg::SEG_W-1:0];
        if (seg_up >= used) begin
            n_seg = '0;
            if (!r_repeat) begin
                n_halted = 1'b1;
                n_pos    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= pwle_pkg::SEGCNT_RST;
            r_repeat    <= 1'b0;
            r_inc       <= pwle_pkg::INC_RST;
        end else if (i_cfg_we) begin
            unique case (pwle_pkg::t_cfg_idx'(i_cfg_idx))
                pwle_pkg::CFG_SEG_COUNT: r_seg_count <= i_cfg_data[pwle_pkg::SEGCNT_W-1:0];
                pwle_pkg::CFG_REPEAT:    r_repeat    <= i_cfg_data[0];
                pwle_pkg::CFG_INC:       r_inc       <= i_cfg_data[pwle_pkg::INC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pwle_pkg::SEGMENTS; i++) begin
                r_start[i] <= '0;
                r_end[i]   <= '0;
                r_dur[i]   <= '0;
            end
        end else if (i_cmd.do_load) begin
            r_end[i_seg_index] <= i_end_level;
            r_dur[i_seg_index] <= i_seg_length;
            if (pwle_pkg::SEGCNT_W'(i_seg_index) + pwle_pkg::SEGCNT_W'(1) < used) begin
                r_start[nxt_idx] <= i_end_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_seg    <= '0;
            r_halted <= 1'b1;
        end else if (i_cmd.do_trig) begin
            r_pos    <= '0;
            r_seg    <= '0;
            r_halted <= 1'b0;
        end else if (i_cmd.out_push && !r_halted) begin
            r_pos    <= n_pos;
            r_seg    <= n_seg;
            r_halted <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.abs_en) begin
            r_cnt <= pwle_pkg::DIV_CNT_W'(pwle_pkg::DIV_STEPS);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - pwle_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= diff * $signed({1'b0, r_pos});
        end
        if (i_cmd.abs_en) begin
            r_sign <= r_prod[pwle_pkg::PROD_W-1];
            r_dq   <= r_prod[pwle_pkg::PROD_W-1] ? neg_prod[pwle_pkg::MAG_W-1:0]
                                                 : r_prod[pwle_pkg::MAG_W-1:0];
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? rem_sub[pwle_pkg::LEN_W-1:0] : rem_sh[pwle_pkg::LEN_W-1:0];
            r_dq  <= {r_dq[pwle_pkg::MAG_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_push) begin
            r_out_level   <= lvl_res;
            r_out_running <= !r_halted;
            r_out_seg     <= r_seg;
        end
    end

    assign o_stat.div_last   = (r_cnt == pwle_pkg::DIV_CNT_W'(1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_level           = r_out_level;
    assign o_running         = r_out_running;
    assign o_current_segment = r_out_seg;

    // A stopped envelope always sits at the start of segment 0.
    a_halt_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_pos == '0 && r_seg == '0))
        else $error("halted envelope away from segment 0, position 0");

    // A result is pushed only when the output register can take it.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_push |-> (!r_out_valid || i_out_ready))
        else $error("result pushed over a pending result");

    // The divider is stepped only while steps remain.
    a_step_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_cnt != '0))
        else $error("division step with no steps left");

    // The partial remainder stays below a nonzero divisor during division.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && cur_len != '0) |-> (r_rem < cur_len))
        else $error("division remainder out of range");

endmodule

`default_nettype wire

@@ src/piecewise_linear_envelope.sv @@
`default_nettype none

// Multi-segment linear envelope generator. Load beats set one segment's end
// level and length, and the same level becomes the start of the following
// segment while that segment is within the segment count; segment 0 always
// starts at zero. A trigger beat restarts the envelope at segment 0, position 0,
// and sets it running. Each tick beat returns one result beat carrying the
// level interpolated inside the active segment (start plus the level change
// times position over length, truncated toward zero and saturated to Q1.15, or
// the end level for a zero length), the running flag and the segment number,
// and then, if running, advances the position by the phase increment. Load and
// trigger beats are carried out as they are accepted and return nothing; an
// op code of three is accepted and ignored. A tick occupies the block from
// its acceptance through the signed multiply, taking the product's magnitude,
// the bit-serial restoring divider (one quotient bit per cycle) and the final
// step that saturates and loads the output register. The result waits in the
// output register, and the next beat can be accepted in the cycle after it is
// loaded even if the result has not yet been taken; a further tick then holds
// in its final step until the output register frees.
// Configuration registers are written through the plain write port and should
// only be changed while no tick is in progress.
module piecewise_linear_envelope (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    pwle_in_if.sink                                     i_in,
    pwle_out_if.source                                  o_out,
    input  wire logic                                   i_cfg_we,
    input  wire logic [pwle_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [pwle_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    pwle_pkg::t_dp_cmd  cmd;
    pwle_pkg::t_dp_stat stat;
    logic               in_ready;

    // The controller sequences a tick through multiply, magnitude, divide and
    // output; loads and triggers are carried out at the accepting edge.
    pwle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // The datapath holds the configuration, the segment table, the position
    // state, the interpolation arithmetic and the output register.
    pwle_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_seg_index       (i_in.seg_index),
        .i_end_level       (i_in.end_level),
        .i_seg_length      (i_in.seg_length),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_level           (o_out.level),
        .o_running         (o_out.running),
        .o_current_segment (o_out.current_segment)
    );

endmodule

`default_nettype wire

@@ bench/tb_piecewise_linear_envelope.sv @@
`timescale 1ns / 1ps

module tb_piecewise_linear_envelope;
    import pwle_pkg::*;

    // The code that the block accepts and drops without a result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // The largest segment count that has any effect.
    localparam int SEG_LIMIT = (SEGMENTS < 8) ? SEGMENTS : 8;
    localparam logic [POS_W:0] POS_LIMIT = 26'h1FFFFFF;

    // Cycles to let pass once the last sample is in. This is longer than a tick
    // takes inside the block, so it also covers a trailing load or unused beat.
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES = 600;
    localparam int HOLD_AFTER_TICKS = 400;

    typedef struct packed {
        logic [OP_W-1:0]             op;
        logic [SEG_W-1:0]            idx;
        logic signed [LEVEL_W-1:0]   lvl;
        logic [LEN_W-1:0]            len;
    } env_cmd_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0]   level;
        logic                        running;
        logic [SEG_W-1:0]            seg;
    } env_sample_t;

    logic clk;
    logic rst_n = 1'b0;

    // Everything the bench drives starts at a known value.
    logic                        in_valid = 1'b0;
    logic [OP_W-1:0]             in_op = OP_TICK;
    logic [SEG_W-1:0]            in_idx = '0;
    logic signed [LEVEL_W-1:0]   in_lvl = '0;
    logic [LEN_W-1:0]            in_len = '0;
    logic                        out_ready = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_idx = CFG_SEG_COUNT;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    pwle_in_if  in_if ();
    pwle_out_if out_if ();

    assign in_if.valid      = in_valid;
    assign in_if.op         = in_op;
    assign in_if.seg_index  = in_idx;
    assign in_if.end_level  = in_lvl;
    assign in_if.seg_length = in_len;
    assign out_if.ready     = out_ready;

    piecewise_linear_envelope u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Envelope predictor. It keeps its own copy of the segment table, the
    // running position and the three registers, and is stepped once for
    // every beat that the block accepts.
    // ------------------------------------------------------------------
    logic signed [LEVEL_W-1:0]   seg_start [SEGMENTS];
    logic signed [LEVEL_W-1:0]   seg_end [SEGMENTS];
    logic [LEN_W-1:0]            seg_len [SEGMENTS];
    logic [POS_W-1:0]            env_pos;
    int                          env_seg;
    logic                        env_halted;
    logic [SEGCNT_W-1:0]         cnt_reg;
    logic                        rep_reg;
    logic [INC_W-1:0]            inc_reg;

    // Samples the block still owes us, oldest first.
    env_sample_t due_samples[$];
    // Beats waiting to be offered on the input channel.
    env_cmd_t cmd_queue[$];

    // A count of zero behaves as one, and anything past the table as the table.
    function automatic int active_count();
        int n;
        n = cnt_reg;
        if (n < 1) n = 1;
        if (n > SEG_LIMIT) n = SEG_LIMIT;
        return n;
    endfunction

    // Straight-line interpolation inside one segment, truncated toward zero.
    // A position beyond the length extrapolates, so the sum is clamped.
    function automatic logic signed [LEVEL_W-1:0] level_at(int seg);
        longint s;
        longint e;
        longint v;
        s = seg_start[seg];
        e = seg_end[seg];
        if (seg_len[seg] == 0) return seg_end[seg];
        v = s + ((e - s) * longint'(env_pos)) / longint'(seg_len[seg]);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return LEVEL_W'(v);
    endfunction

    function automatic void step_envelope(env_cmd_t c);
        env_sample_t smp;
        logic [POS_W:0] p;
        int seg;
        case (c.op)
            OP_LOAD: begin
                seg_end[c.idx] = c.lvl;
                seg_len[c.idx] = c.len;
                // The next segment only inherits the level inside the count.
                if (int'(c.idx) + 1 < active_count() && int'(c.idx) + 1 < SEGMENTS)
                    seg_start[c.idx + 1] = c.lvl;
            end
            OP_TRIG: begin
                env_halted = 1'b0;
                env_pos = '0;
                env_seg = 0;
            end
            OP_TICK: begin
                smp.level = level_at(env_seg);
                smp.running = !env_halted;
                smp.seg = SEG_W'(env_seg);
                due_samples.push_back(smp);
                if (!env_halted) begin
                    seg = env_seg;
                    p = {1'b0, env_pos} + (POS_W+1)'(inc_reg);
                    if (p > POS_LIMIT) p = POS_LIMIT;
                    // At most one segment boundary is crossed per tick.
                    if (p > seg_len[seg]) begin
                        p = p - seg_len[seg];
                        seg = seg + 1;
                    end
                    if (seg >= active_count()) begin
                        seg = 0;
                        if (!rep_reg) begin
                            env_halted = 1'b1;
                            p = '0;
                        end
                    end
                    env_seg = seg;
                    env_pos = p[POS_W-1:0];
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Idle patterns. Most gaps are zero or a few cycles, a few are long;
    // in a quiet phase neither side idles at all.
    // ------------------------------------------------------------------
    bit quiet_phase = 1'b0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Input driver. A beat stays on the channel until it is taken, then
    // the next one follows after a random gap.
    // ------------------------------------------------------------------
    logic        in_fire = 1'b0;
    int unsigned in_gap = 0;
    env_cmd_t    drive_cmd;

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_fire) begin
            // Still waiting for the block to take the current beat.
        end else if (in_gap != 0) begin
            in_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (cmd_queue.size() != 0) begin
            drive_cmd = cmd_queue.pop_front();
            in_valid <= 1'b1;
            in_op <= drive_cmd.op;
            in_idx <= drive_cmd.idx;
            in_lvl <= drive_cmd.lvl;
            in_len <= drive_cmd.len;
            in_gap <= pick_gap();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver. The long hold-off is counted in its own process: it
    // starts once enough ticks have gone in, and meanwhile the driver keeps
    // offering beats so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    int unsigned out_gap = 0;
    int          hold_left = 0;
    bit          hold_used = 1'b0;
    int          ticks_taken = 0;

    always @(negedge clk) begin
        if (!hold_used && ticks_taken >= HOLD_AFTER_TICKS) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
        end else if (out_gap != 0) begin
            out_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end else begin
            out_ready <= 1'b1;
            out_gap <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Result beats are checked before the input beat of the same
    // edge is predicted; a sample can never come out on the edge that took
    // its own tick.
    // ------------------------------------------------------------------
    int          mismatches = 0;
    int          samples_checked = 0;
    int          running_samples = 0;
    int          loads_taken = 0;
    int          trigs_taken = 0;
    int          unused_taken = 0;
    int          in_stalls = 0;
    env_sample_t mon_want;

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_if.valid && out_ready) begin
                samples_checked++;
                if (out_if.running) running_samples++;
                if (due_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result: level=%0d running=%0b seg=%0d",
                                 $realtime, out_if.level, out_if.running,
                                 out_if.current_segment);
                end else begin
                    mon_want = due_samples.pop_front();
                    if (out_if.level !== mon_want.level || out_if.running !== mon_want.running
                            || out_if.current_segment !== mon_want.seg) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: sample %0d want level=%0d running=%0b seg=%0d",
                                     $realtime, samples_checked, mon_want.level,
                                     mon_want.running, mon_want.seg);
                            $display("%0t: sample %0d got  level=%0d running=%0b seg=%0d",
                                     $realtime, samples_checked, out_if.level,
                                     out_if.running, out_if.current_segment);
                        end
                    end
                end
            end
            if (in_valid && !in_if.ready) in_stalls++;
            if (in_valid && in_if.ready) begin
                case (in_op)
                    OP_TICK: ticks_taken++;
                    OP_LOAD: loads_taken++;
                    OP_TRIG: trigs_taken++;
                    default: unused_taken++;
                endcase
                step_envelope('{in_op, in_idx, in_lvl, in_len});
            end
        end
        in_fire <= rst_n && in_valid && in_if.ready;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void push_cmd(logic [OP_W-1:0] op, logic [SEG_W-1:0] idx,
                                     logic signed [LEVEL_W-1:0] lvl, logic [LEN_W-1:0] len);
        cmd_queue.push_back('{op, idx, lvl, len});
    endfunction

    function automatic logic signed [LEVEL_W-1:0] rand_level();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return LEVEL_MAX;
        if (sel == 1) return LEVEL_MIN;
        if (sel == 2) return '0;
        return LEVEL_W'($urandom);
    endfunction

    // Lengths mostly span a few increments so that segments actually end,
    // with zero, the maximum and fully random values mixed in.
    function automatic logic [LEN_W-1:0] rand_len();
        int unsigned sel;
        longint lim;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        if (sel == 2) return LEN_W'($urandom);
        lim = longint'(inc_reg) * 6;
        if (lim > 24'hFFFFFF) lim = 24'hFFFFFF;
        if (lim < 16) lim = 16;
        return LEN_W'($urandom_range(0, int'(lim)));
    endfunction

    function automatic void push_tick();
        push_cmd(OP_TICK, SEG_W'($urandom), LEVEL_W'($urandom), LEN_W'($urandom));
    endfunction

    // A register is written while the block is idle, so the predictor copy
    // can follow at once.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SEG_COUNT: cnt_reg = val[SEGCNT_W-1:0];
            CFG_REPEAT:    rep_reg = val[0];
            CFG_INC:       inc_reg = val[INC_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued beat is in and every due sample is out, then
    // give the block time to finish whatever it is still working on. The
    // check is made at rising edges, where the driven beat is stable.
    task automatic settle();
        do @(posedge clk);
        while (cmd_queue.size() != 0 || in_valid || due_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random traffic. Most of it is a proper envelope: segments loaded from
    // zero upward, a trigger, then a run of ticks, sometimes with a load in
    // the middle. The rest is raw noise and fragments such as ticks with no
    // trigger or a trigger in the middle of a run.
    task automatic gen_phase(int quota);
        int made;
        int k;
        int n;
        int i;
        int unsigned r;
        logic [OP_W-1:0] op;
        made = 0;
        while (made < quota) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                k = $urandom_range(1, active_count());
                for (i = 0; i < k; i++) begin
                    push_cmd(OP_LOAD, SEG_W'(i), rand_level(), rand_len());
                    made++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    push_cmd(OP_LOAD, SEG_W'($urandom), rand_level(), rand_len());
                    made++;
                end
                push_cmd(OP_TRIG, SEG_W'($urandom), LEVEL_W'($urandom), LEN_W'($urandom));
                made++;
                n = $urandom_range(4, 40);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        push_cmd(OP_LOAD, SEG_W'($urandom_range(0, k - 1)), rand_level(),
                                 rand_len());
                        made++;
                    end
                    push_tick();
                    made++;
                end
            end else if (r < 90) begin
                op = OP_W'($urandom);
                push_cmd(op, SEG_W'($urandom), LEVEL_W'($urandom), LEN_W'($urandom));
                if (op != OP_UNUSED) made++;
            end else begin
                if ($urandom_range(0, 1) == 1) begin
                    push_cmd(OP_TRIG, SEG_W'($urandom), LEVEL_W'($urandom),
                             LEN_W'($urandom));
                    made++;
                end
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++) begin
                    push_tick();
                    made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    int unsigned phase_cnt [7] = '{4, 8, 1, 0, 15, 3, 8};
    int unsigned phase_rep [7] = '{0, 1, 1, 0, 1, 0, 0};
    int unsigned phase_inc [7] = '{256, 5000, 24'hFFFFFF, 1000, 300, 0, 1};

    initial begin : stimulus
        int ph;
        int i;
        int unsigned c_val;
        int unsigned r_val;
        int unsigned i_val;

        for (i = 0; i < SEGMENTS; i++) begin
            seg_start[i] = '0;
            seg_end[i] = '0;
            seg_len[i] = '0;
        end
        env_pos = '0;
        env_seg = 0;
        env_halted = 1'b1;
        cnt_reg = SEGCNT_RST;
        rep_reg = 1'b0;
        inc_reg = INC_RST;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A tick straight out of reset: stopped, segment 0, level zero.
        push_tick();
        settle();

        write_reg(CFG_SEG_COUNT, CFG_DATA_W'(4));
        write_reg(CFG_REPEAT, '0);
        write_reg(CFG_INC, CFG_DATA_W'(900));
        @(posedge clk);

        // Directed run. With an increment of 900 the envelope leaves
        // segment 0 on its second advance, lands far past the end of the
        // ten-unit segment 1 (extrapolation that clamps high), passes the
        // zero-length segment 2 and settles in the longest possible segment.
        push_cmd(OP_UNUSED, '1, '1, '1);
        push_cmd(OP_LOAD, 3'd0, LEVEL_MIN, 24'd1000);
        push_cmd(OP_LOAD, 3'd1, LEVEL_MAX, 24'd10);
        push_cmd(OP_LOAD, 3'd2, '0, '0);
        push_cmd(OP_LOAD, 3'd3, 16'sd12345, '1);
        // Past the count: stored, but segment 7 keeps its start level.
        push_cmd(OP_LOAD, 3'd6, -16'sd1, 24'd5);
        push_cmd(OP_TICK, '0, '0, '0);
        push_cmd(OP_TRIG, '0, '0, '0);
        for (i = 0; i < 7; i++) push_cmd(OP_TICK, '0, '0, '0);
        // Restart in the middle of a run, then rewrite the live segment.
        push_cmd(OP_TRIG, '1, '1, '1);
        push_cmd(OP_TICK, '1, '1, '1);
        push_cmd(OP_LOAD, 3'd0, LEVEL_MAX, '1);
        push_cmd(OP_TICK, '0, '0, '0);
        push_cmd(OP_TICK, '0, '0, '0);

        // Random phases, each under its own register setting, covering the
        // extremes of all three registers including out-of-range counts.
        for (ph = 0; ph < 8; ph++) begin
            settle();
            if (ph < 7) begin
                c_val = phase_cnt[ph];
                r_val = phase_rep[ph];
                i_val = phase_inc[ph];
            end else begin
                c_val = $urandom_range(0, 15);
                r_val = $urandom_range(0, 1);
                i_val = $urandom_range(0, 24'hFFFFFF);
            end
            write_reg(CFG_SEG_COUNT, CFG_DATA_W'(c_val));
            write_reg(CFG_REPEAT, CFG_DATA_W'(r_val));
            write_reg(CFG_INC, CFG_DATA_W'(i_val));
            @(posedge clk);
            quiet_phase = (ph % 3 == 2);
            gen_phase(250);
        end

        settle();
        $display("Covered %0d tick, %0d load, %0d trigger and %0d unused-code beats",
                 ticks_taken, loads_taken, trigs_taken, unused_taken);
        $display("under 9 register settings; checked %0d samples (%0d while running), %0s%0d.",
                 samples_checked, running_samples, "input stall cycles ", in_stalls);
        if (mismatches == 0 && due_samples.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Safety net far beyond the slowest correct run.
    initial begin : watchdog
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
